// ----- src/ppnd_pkg.sv -----
// Shared types, widths and helpers for the point-to-polyline nearest distance block.
package ppnd_pkg;

    // Coordinate width of every vertex and query field
    localparam int COORD_BITS = 24;
    // Width of a coordinate difference (one bit of growth)
    localparam int DIFF_W     = COORD_BITS + 1;
    // Signed product of two differences; also holds the squared segment length
    localparam int PROD_W     = 2 * DIFF_W;
    // Dot product: sum of two signed products
    localparam int DOT_W      = PROD_W + 1;
    // Sum of two squared offsets
    localparam int DSUM_W     = PROD_W + 1;
    // Running remainder plus one added term in the divider
    localparam int REM_W      = PROD_W + 2;
    // Quotient register, one bit of headroom over the final value
    localparam int QUO_W      = DIFF_W + 1;
    // Divider step counter, counts up to DIFF_W
    localparam int DCNT_W     = $clog2(DIFF_W + 1);
    // Reported squared distance
    localparam int DIST_BITS  = 50;
    localparam int WIDE_W     = (DSUM_W > DIST_BITS) ? DSUM_W : DIST_BITS;
    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

    // Segment queue depth (power of two so the pointers wrap naturally)
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // Input word: one polyline vertex with its query point
    typedef struct packed {
        logic signed [COORD_BITS-1:0] vertex_x;
        logic signed [COORD_BITS-1:0] vertex_y;
        logic signed [COORD_BITS-1:0] query_x;
        logic signed [COORD_BITS-1:0] query_y;
        logic                         first_vertex;
        logic                         last_vertex;
    } t_in_word;

    // Output word: the result of one polyline
    typedef struct packed {
        logic [DIST_BITS-1:0]         dist_squared;
        logic signed [COORD_BITS-1:0] near_x;
        logic signed [COORD_BITS-1:0] near_y;
        logic                         has_segment;
    } t_out_word;

    // Queue entry: one classified vertex ready for the back end
    typedef struct packed {
        logic signed [COORD_BITS-1:0] x1;
        logic signed [COORD_BITS-1:0] y1;
        logic signed [COORD_BITS-1:0] x2;
        logic signed [COORD_BITS-1:0] y2;
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
        logic                         seg;
        logic                         clr;
        logic                         last;
    } t_seg_entry;

    // Back end sequencer states
    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_CLASS,
        B_DIV,
        B_DMUL,
        B_CMP,
        B_EMIT
    } t_back_state;

    // Sign-extend a coordinate to difference width
    function automatic logic signed [DIFF_W-1:0] sext_diff(input logic [COORD_BITS-1:0] v);
        return $signed({v[COORD_BITS-1], v});
    endfunction

    // Clamp a squared distance to the reported width
    function automatic logic [DIST_BITS-1:0] sat_dist(input logic [DSUM_W-1:0] v);
        logic [WIDE_W-1:0] w;
        logic [WIDE_W-1:0] lim;
        w   = WIDE_W'(v);
        lim = WIDE_W'(DIST_MAX);
        if (w > lim) begin
            w = lim;
        end
        return w[DIST_BITS-1:0];
    endfunction

endpackage

// ----- src/point_polyline_nearest_distance.sv -----
// Top level of the point-to-polyline nearest squared distance block.
//
// Usage: send polyline vertices one word at a time on the input channel, each word
// carrying the query point; first_vertex opens a polyline, last_vertex closes it.
// Consecutive vertices form segments. After the last vertex one result word leaves on
// the output channel: the minimum squared distance, the nearest point and a flag that
// says whether any segment was seen.
// Timing: a vertex that closes a segment spends most of its time in the back end in the
// bit-serial divider that scales the projection when that projection falls inside the
// segment, one quotient bit per cycle on both axes in parallel; a projection clamped to
// an end point skips the divider. A vertex that opens a polyline is taken from the queue
// without entering the segment sequence. A two-word queue lets the front end keep taking
// words while a segment is in progress, so the input stalls only when the queue is full.
// The result word is registered in the emit state that follows the comparison of the
// last segment's distance, once the output register is free.
// Reset clears the queue, the sequencer, the open polyline and the running minimum.
// If the receiver stalls, the result word holds; the back end keeps working and waits
// only when it has a further result to hand over.
module point_polyline_nearest_distance import ppnd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_word  i_in_word,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_word o_out_word,
    input  logic      i_out_stall
);

    logic       w_push;
    logic       w_full;
    logic       w_empty;
    logic       w_pop;
    t_seg_entry w_entry;
    t_seg_entry w_head;

    // Accept and classify vertices
    ppnd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .i_word   (i_in_word),
        .o_stall  (o_in_stall),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_entry  (w_entry)
    );

    // Decouple front and back
    ppnd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_rdata (w_head),
        .o_empty (w_empty)
    );

    // Compute segments and hold the result
    ppnd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_empty),
        .i_q_head    (w_head),
        .o_q_pop     (w_pop),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall)
    );

endmodule

// ----- src/ppnd_front.sv -----
// Front end: accepts vertex words, pairs them with the previous vertex and queues each as an entry.
module ppnd_front import ppnd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_in_word   i_word,
    output logic       o_stall,
    input  logic       i_q_full,
    output logic       o_push,
    output t_seg_entry o_entry
);

    logic                         r_have_prev;
    logic signed [COORD_BITS-1:0] r_prev_x;
    logic signed [COORD_BITS-1:0] r_prev_y;
    logic                         w_accept;

    // Hold the input off while the queue is full
    assign o_stall  = i_q_full;
    assign w_accept = i_valid && !i_q_full;
    assign o_push   = w_accept;

    // Classify: a segment exists only inside a running polyline
    always_comb begin
        o_entry.x1   = r_prev_x;
        o_entry.y1   = r_prev_y;
        o_entry.x2   = i_word.vertex_x;
        o_entry.y2   = i_word.vertex_y;
        o_entry.px   = i_word.query_x;
        o_entry.py   = i_word.query_y;
        o_entry.seg  = r_have_prev && !i_word.first_vertex;
        o_entry.clr  = i_word.first_vertex || !r_have_prev;
        o_entry.last = i_word.last_vertex;
    end

    // Track whether a polyline is open
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
        end else if (w_accept) begin
            r_have_prev <= !i_word.last_vertex;
        end
    end

    // Keep the latest vertex as the start of the next segment
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_prev_x <= i_word.vertex_x;
            r_prev_y <= i_word.vertex_y;
        end
    end

endmodule

// ----- src/ppnd_fifo.sv -----
// Short queue of classified vertex entries between the front end and the back end.
module ppnd_fifo import ppnd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_seg_entry i_wdata,
    output logic       o_full,
    input  logic       i_pop,
    output t_seg_entry o_rdata,
    output logic       o_empty
);

    t_seg_entry       r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr_ptr;
    logic [Q_AW-1:0]  r_rd_ptr;
    logic [Q_AW:0]    r_count;

    assign o_full  = (r_count == (Q_AW + 1)'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Store the incoming word
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

// ----- src/ppnd_div.sv -----
// Bit-serial unit for round(num * mag / den), one bit of mag per cycle, then a rounding step.
module ppnd_div import ppnd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [PROD_W-1:0] i_num,
    input  logic [DIFF_W-1:0] i_mag,
    input  logic [PROD_W-1:0] i_den,
    output logic              o_done,
    output logic [DIFF_W-1:0] o_quo
);

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [PROD_W-1:0] r_num;
    logic [DIFF_W-1:0] r_mag;
    logic [PROD_W-1:0] r_den;
    logic [PROD_W-1:0] r_rem;
    logic [QUO_W-1:0]  r_quo;

    logic [REM_W-1:0]  w_sum;
    logic [REM_W-1:0]  w_den1;
    logic [REM_W-1:0]  w_den2;
    logic [REM_W-1:0]  w_rem_nx;
    logic [1:0]        w_wrap;
    logic              w_round;
    logic              w_last;

    assign w_last = (r_cnt == DCNT_W'(DIFF_W));

    // Double the remainder, add num on a set bit, reduce by den or twice den
    always_comb begin
        w_sum  = {1'b0, r_rem, 1'b0} + (r_mag[DIFF_W-1] ? REM_W'(r_num) : '0);
        w_den1 = REM_W'(r_den);
        w_den2 = {1'b0, r_den, 1'b0};
        if (w_sum >= w_den2) begin
            w_rem_nx = w_sum - w_den2;
            w_wrap   = 2'd2;
        end else if (w_sum >= w_den1) begin
            w_rem_nx = w_sum - w_den1;
            w_wrap   = 2'd1;
        end else begin
            w_rem_nx = w_sum;
            w_wrap   = 2'd0;
        end
        w_round = ({r_rem, 1'b0} >= {1'b0, r_den});
    end

    // Control: busy over all bits plus the rounding step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && w_last) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath: load, shift one bit per cycle, round at the end
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_mag <= i_mag;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            if (w_last) begin
                if (w_round) begin
                    r_quo <= r_quo + 1'b1;
                end
            end else begin
                r_mag <= {r_mag[DIFF_W-2:0], 1'b0};
                r_rem <= w_rem_nx[PROD_W-1:0];
                r_quo <= {r_quo[QUO_W-2:0], 1'b0} + QUO_W'(w_wrap);
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo[DIFF_W-1:0];

endmodule

// ----- src/ppnd_back.sv -----
// Back end: per-segment projection, distance and running minimum, and the result register.
module ppnd_back import ppnd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_empty,
    input  t_seg_entry i_q_head,
    output logic       o_q_pop,
    output logic       o_out_valid,
    output t_out_word  o_out_word,
    input  logic       i_out_stall
);

    localparam logic [2:0] MulLast  = 3'd4;
    localparam logic [2:0] DmulLast = 3'd2;

    t_back_state r_state;
    t_back_state n_state;

    t_seg_entry                   r_ent;
    logic signed [DIFF_W-1:0]     r_dx;
    logic signed [DIFF_W-1:0]     r_dy;
    logic signed [DIFF_W-1:0]     r_ex;
    logic signed [DIFF_W-1:0]     r_ey;
    logic [2:0]                   r_step;
    logic signed [PROD_W-1:0]     r_prod;
    logic [PROD_W-1:0]            r_len2;
    logic signed [DOT_W-1:0]      r_dot;
    logic signed [COORD_BITS-1:0] r_nx;
    logic signed [COORD_BITS-1:0] r_ny;
    logic [DSUM_W-1:0]            r_dsum;
    logic [DIST_BITS-1:0]         r_best_dist;
    logic signed [COORD_BITS-1:0] r_best_x;
    logic signed [COORD_BITS-1:0] r_best_y;
    logic                         r_seen;
    t_out_word                    r_out;
    logic                         r_out_valid;

    logic signed [DIFF_W-1:0]     w_op_a;
    logic signed [DIFF_W-1:0]     w_op_b;
    logic signed [PROD_W-1:0]     w_prod;
    logic signed [DIFF_W-1:0]     w_ux;
    logic signed [DIFF_W-1:0]     w_uy;
    logic                         w_to_p1;
    logic                         w_to_p2;
    logic                         w_div_start;
    logic                         w_done_x;
    logic                         w_done_y;
    logic [DIFF_W-1:0]            w_ax;
    logic [DIFF_W-1:0]            w_ay;
    logic [DIFF_W-1:0]            w_qx;
    logic [DIFF_W-1:0]            w_qy;
    logic signed [DIFF_W:0]       w_nx_full;
    logic signed [DIFF_W:0]       w_ny_full;
    logic [DIST_BITS-1:0]         w_dist;
    logic                         w_out_free;
    logic                         w_pop;

    // Shared multiplier and helper terms
    assign w_prod  = w_op_a * w_op_b;
    assign w_ux    = sext_diff(r_ent.px) - sext_diff(r_nx);
    assign w_uy    = sext_diff(r_ent.py) - sext_diff(r_ny);
    assign w_to_p1 = (r_len2 == '0) || r_dot[DOT_W-1] || (r_dot == '0);
    assign w_to_p2 = !w_to_p1 && (r_dot[PROD_W-1:0] >= r_len2);
    assign w_ax    = r_dx[DIFF_W-1] ? DIFF_W'(-r_dx) : DIFF_W'(r_dx);
    assign w_ay    = r_dy[DIFF_W-1] ? DIFF_W'(-r_dy) : DIFF_W'(r_dy);
    assign w_nx_full = r_dx[DIFF_W-1]
                     ? {r_ent.x1[COORD_BITS-1], sext_diff(r_ent.x1)} - $signed({1'b0, w_qx})
                     : {r_ent.x1[COORD_BITS-1], sext_diff(r_ent.x1)} + $signed({1'b0, w_qx});
    assign w_ny_full = r_dy[DIFF_W-1]
                     ? {r_ent.y1[COORD_BITS-1], sext_diff(r_ent.y1)} - $signed({1'b0, w_qy})
                     : {r_ent.y1[COORD_BITS-1], sext_diff(r_ent.y1)} + $signed({1'b0, w_qy});
    assign w_dist     = sat_dist(r_dsum);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // One divider lane per axis
    ppnd_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_dot[PROD_W-1:0]),
        .i_mag   (w_ax),
        .i_den   (r_len2),
        .o_done  (w_done_x),
        .o_quo   (w_qx)
    );

    ppnd_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_dot[PROD_W-1:0]),
        .i_mag   (w_ay),
        .i_den   (r_len2),
        .o_done  (w_done_y),
        .o_quo   (w_qy)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    if (i_q_head.seg) begin
                        n_state = B_MUL;
                    end else if (i_q_head.last) begin
                        n_state = B_EMIT;
                    end
                end
            end
            B_MUL: begin
                if (r_step == MulLast) begin
                    n_state = B_CLASS;
                end
            end
            B_CLASS: begin
                n_state = (w_to_p1 || w_to_p2) ? B_DMUL : B_DIV;
            end
            B_DIV: begin
                if (w_done_x && w_done_y) begin
                    n_state = B_DMUL;
                end
            end
            B_DMUL: begin
                if (r_step == DmulLast) begin
                    n_state = B_CMP;
                end
            end
            B_CMP: begin
                n_state = r_ent.last ? B_EMIT : B_IDLE;
            end
            B_EMIT: begin
                if (w_out_free) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // Sequencer outputs: queue pop, divider start, multiplier operands
    always_comb begin
        w_pop       = 1'b0;
        w_div_start = 1'b0;
        w_op_a      = r_dx;
        w_op_b      = r_dx;
        unique case (r_state)
            B_IDLE: begin
                w_pop = !i_q_empty;
            end
            B_MUL: begin
                case (r_step)
                    3'd0: begin
                        w_op_a = r_dx;
                        w_op_b = r_dx;
                    end
                    3'd1: begin
                        w_op_a = r_dy;
                        w_op_b = r_dy;
                    end
                    3'd2: begin
                        w_op_a = r_ex;
                        w_op_b = r_dx;
                    end
                    default: begin
                        w_op_a = r_ey;
                        w_op_b = r_dy;
                    end
                endcase
            end
            B_CLASS: begin
                w_div_start = !(w_to_p1 || w_to_p2);
            end
            B_DMUL: begin
                if (r_step == 3'd0) begin
                    w_op_a = w_ux;
                    w_op_b = w_ux;
                end else begin
                    w_op_a = w_uy;
                    w_op_b = w_uy;
                end
            end
            B_DIV, B_CMP, B_EMIT: begin
                w_pop = 1'b0;
            end
            default: w_pop = 1'b0;
        endcase
    end

    assign o_q_pop = w_pop;

    // State, running minimum and result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
            r_best_dist <= DIST_MAX;
            r_best_x    <= '0;
            r_best_y    <= '0;
            r_seen      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_EMIT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            // Clear the run on a new polyline or after a result
            if ((w_pop && i_q_head.clr) || (r_state == B_EMIT && w_out_free)) begin
                r_best_dist <= DIST_MAX;
                r_best_x    <= '0;
                r_best_y    <= '0;
                r_seen      <= 1'b0;
            end else if (r_state == B_CMP) begin
                r_seen <= 1'b1;
                // Strictly smaller only: first minimum wins ties
                if (w_dist < r_best_dist) begin
                    r_best_dist <= w_dist;
                    r_best_x    <= r_nx;
                    r_best_y    <= r_ny;
                end
            end
        end
    end

    // Segment datapath
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        unique case (r_state)
            B_IDLE: begin
                if (w_pop) begin
                    r_ent  <= i_q_head;
                    r_dx   <= sext_diff(i_q_head.x2) - sext_diff(i_q_head.x1);
                    r_dy   <= sext_diff(i_q_head.y2) - sext_diff(i_q_head.y1);
                    r_ex   <= sext_diff(i_q_head.px) - sext_diff(i_q_head.x1);
                    r_ey   <= sext_diff(i_q_head.py) - sext_diff(i_q_head.y1);
                    r_step <= '0;
                end
            end
            B_MUL: begin
                // Accumulate the previous cycle's product
                case (r_step)
                    3'd1: r_len2 <= PROD_W'($unsigned(r_prod));
                    3'd2: r_len2 <= r_len2 + PROD_W'($unsigned(r_prod));
                    3'd3: r_dot  <= DOT_W'(r_prod);
                    3'd4: r_dot  <= r_dot + DOT_W'(r_prod);
                    default: r_len2 <= r_len2;
                endcase
                r_step <= (r_step == MulLast) ? 3'd0 : r_step + 1'b1;
            end
            B_CLASS: begin
                // Clamp to an end point; the divider overwrites otherwise
                if (w_to_p2) begin
                    r_nx <= r_ent.x2;
                    r_ny <= r_ent.y2;
                end else begin
                    r_nx <= r_ent.x1;
                    r_ny <= r_ent.y1;
                end
                r_step <= '0;
            end
            B_DIV: begin
                if (w_done_x && w_done_y) begin
                    r_nx <= w_nx_full[COORD_BITS-1:0];
                    r_ny <= w_ny_full[COORD_BITS-1:0];
                end
            end
            B_DMUL: begin
                case (r_step)
                    3'd1: r_dsum <= DSUM_W'($unsigned(r_prod));
                    3'd2: r_dsum <= r_dsum + DSUM_W'($unsigned(r_prod));
                    default: r_dsum <= r_dsum;
                endcase
                r_step <= (r_step == DmulLast) ? 3'd0 : r_step + 1'b1;
            end
            B_EMIT: begin
                if (w_out_free) begin
                    r_out.dist_squared <= r_best_dist;
                    r_out.near_x       <= r_best_x;
                    r_out.near_y       <= r_best_y;
                    r_out.has_segment  <= r_seen;
                end
            end
            B_CMP: begin
                r_step <= '0;
            end
            default: r_step <= '0;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

// ----- test/point_polyline_nearest_distance_tb.sv -----
// Self-checking testbench for the point-to-polyline nearest squared distance block.
module point_polyline_nearest_distance_tb;
    import ppnd_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 120;
    localparam int PHASE_VERTICES = 280;
    localparam int PHASE_BROKEN   = 30;
    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_word  in_word   = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_word out_word;
    logic      out_stall = 1'b0;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int faults        = 0;
    int vertices_sent = 0;
    int results_seen  = 0;
    int results_with_segment = 0;
    int quiet_cycles  = 0;

    // Running state of the open polyline as the block should hold it
    longint                 trail_x, trail_y;
    bit                     trail_open;
    logic [DIST_BITS-1:0]   run_best_dist;
    longint                 run_best_x, run_best_y;
    bit                     run_has_segment;
    t_out_word              awaited_results[$];
    t_out_word              want;

    point_polyline_nearest_distance DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_word   (in_word),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_word  (out_word),
        .i_out_stall (out_stall)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Drop the open polyline and its running minimum
    task automatic restart_run();
        trail_open      = 1'b0;
        run_best_dist   = DIST_MAX;
        run_best_x      = 0;
        run_best_y      = 0;
        run_has_segment = 1'b0;
    endtask

    // Offset along one axis: round(dot * |delta| / len2), halves away from zero
    function automatic longint step_toward(input longint base, input longint delta,
                                           input longint dot, input longint len2);
        logic [127:0] num;
        logic [127:0] quo;
        logic [127:0] rem;
        num = 128'(dot) * 128'((delta < 0) ? -delta : delta);
        quo = num / 128'(len2);
        rem = num % 128'(len2);
        if (rem >= 128'(len2) - rem) begin
            quo = quo + 1;
        end
        return (delta < 0) ? base - longint'(quo[63:0]) : base + longint'(quo[63:0]);
    endfunction

    // Fold one accepted vertex word into the running minimum; queue a result on the last
    task automatic track_vertex(input t_in_word w);
        longint      vx, vy, qx, qy, dx, dy, dot, len2, nx, ny, ux, uy;
        logic [63:0] dsq;
        t_out_word   res;
        vx = longint'($signed(w.vertex_x));
        vy = longint'($signed(w.vertex_y));
        qx = longint'($signed(w.query_x));
        qy = longint'($signed(w.query_y));
        if (w.first_vertex) begin
            restart_run();
        end
        if (trail_open) begin
            dx   = vx - trail_x;
            dy   = vy - trail_y;
            len2 = dx * dx + dy * dy;
            nx   = trail_x;
            ny   = trail_y;
            if (len2 != 0) begin
                dot = (qx - trail_x) * dx + (qy - trail_y) * dy;
                if (dot >= len2) begin
                    nx = vx;
                    ny = vy;
                end else if (dot > 0) begin
                    nx = step_toward(trail_x, dx, dot, len2);
                    ny = step_toward(trail_y, dy, dot, len2);
                end
            end
            ux  = qx - nx;
            uy  = qy - ny;
            dsq = ux * ux + uy * uy;
            if (dsq > 64'(DIST_MAX)) begin
                dsq = 64'(DIST_MAX);
            end
            // strict compare: the first minimum holds on a tie
            if (dsq < 64'(run_best_dist)) begin
                run_best_dist = dsq[DIST_BITS-1:0];
                run_best_x    = nx;
                run_best_y    = ny;
            end
            run_has_segment = 1'b1;
        end
        trail_x    = vx;
        trail_y    = vy;
        trail_open = 1'b1;
        if (w.last_vertex) begin
            res.dist_squared = run_best_dist;
            res.near_x       = run_best_x[COORD_BITS-1:0];
            res.near_y       = run_best_y[COORD_BITS-1:0];
            res.has_segment  = run_has_segment;
            awaited_results.push_back(res);
            restart_run();
        end
    endtask

    // Offer one vertex word, with random idle cycles in front, and hold it until taken
    task automatic send_vertex(input t_in_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
        track_vertex(w);
        vertices_sent++;
    endtask

    function automatic t_in_word make_word(input int vx, input int vy, input int qx,
                                           input int qy, input bit first, input bit last);
        t_in_word w;
        w.vertex_x     = COORD_BITS'(vx);
        w.vertex_y     = COORD_BITS'(vy);
        w.query_x      = COORD_BITS'(qx);
        w.query_y      = COORD_BITS'(qy);
        w.first_vertex = first;
        w.last_vertex  = last;
        return w;
    endfunction

    // Mostly clustered around the origin, sometimes anywhere, now and then at a rail
    function automatic logic signed [COORD_BITS-1:0] random_coord(input int span);
        int r;
        r = $urandom_range(19);
        if (r == 0) begin
            return COORD_MIN;
        end else if (r == 1) begin
            return COORD_MAX;
        end else if (r < 5) begin
            return COORD_BITS'($urandom);
        end
        return COORD_BITS'(int'($urandom_range(2 * span)) - span);
    endfunction

    function automatic int random_span();
        case ($urandom_range(3))
            0:       return 2;
            1:       return 40;
            2:       return 5000;
            default: return 1 << 22;
        endcase
    endfunction

    // A vertex with no first flag straight after reset opens a polyline anyway
    task automatic test_open_without_first();
        send_vertex(make_word(1, 2, 3, 3, 1'b0, 1'b0));
        send_vertex(make_word(5, 2, 3, 3, 1'b0, 1'b1));
    endtask

    // One-vertex polyline: no segment, saturated distance, zero point
    task automatic test_lone_vertex();
        send_vertex(make_word(-7, 9, 100, -100, 1'b1, 1'b1));
    endtask

    // Full-scale coordinates, an exact half at full scale, and a zero-length segment
    task automatic test_extremes();
        send_vertex(make_word(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, 1'b1, 1'b0));
        send_vertex(make_word(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, 1'b0, 1'b1));
        send_vertex(make_word(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 1'b1, 1'b0));
        send_vertex(make_word(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 1'b0, 1'b0));
        send_vertex(make_word(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN, 1'b0, 1'b1));
    endtask

    // Projection before the start, past the end, and exactly on both ends;
    // the query point also moves from segment to segment
    task automatic test_clamped_projection();
        send_vertex(make_word(0, 0, -5, 3, 1'b1, 1'b0));
        send_vertex(make_word(10, 0, -5, 3, 1'b0, 1'b0));
        send_vertex(make_word(20, 0, 30, 1, 1'b0, 1'b0));
        send_vertex(make_word(20, 0, 0, 7, 1'b1, 1'b0));
        send_vertex(make_word(20, 10, 20, 0, 1'b0, 1'b0));
        send_vertex(make_word(20, 20, 20, 20, 1'b0, 1'b1));
    endtask

    // Interior projection landing on a half, for positive and negative direction
    task automatic test_half_rounding();
        send_vertex(make_word(0, 0, 1, 0, 1'b1, 1'b0));
        send_vertex(make_word(1, 1, 1, 0, 1'b0, 1'b1));
        send_vertex(make_word(0, 0, -1, 0, 1'b1, 1'b0));
        send_vertex(make_word(-1, -1, -1, 0, 1'b0, 1'b1));
    endtask

    // Two segments at the same distance: the earlier one must hold
    task automatic test_tie();
        send_vertex(make_word(0, 0, 5, 5, 1'b1, 1'b0));
        send_vertex(make_word(10, 0, 5, 5, 1'b0, 1'b0));
        send_vertex(make_word(10, 10, 5, 5, 1'b0, 1'b1));
    endtask

    // A first flag in mid-polyline discards what came before
    task automatic test_restart();
        send_vertex(make_word(0, 0, 0, 0, 1'b1, 1'b0));
        send_vertex(make_word(100, 0, 0, 0, 1'b0, 1'b0));
        send_vertex(make_word(3, 3, 0, 0, 1'b1, 1'b0));
        send_vertex(make_word(3, 9, 0, 0, 1'b0, 1'b1));
    endtask

    // Proper polylines with random shape, size and query; some with a roaming query
    task automatic test_well_formed_polylines(input int budget);
        t_in_word w;
        int       spent, n, span, k;
        bit       roaming;
        spent = 0;
        while (spent < budget) begin
            n       = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 6);
            span    = random_span();
            roaming = ($urandom_range(7) == 0);
            w.query_x = random_coord(span);
            w.query_y = random_coord(span);
            for (k = 0; k < n; k++) begin
                if (roaming) begin
                    w.query_x = random_coord(span);
                    w.query_y = random_coord(span);
                end
                w.vertex_x     = random_coord(span);
                w.vertex_y     = random_coord(span);
                w.first_vertex = (k == 0);
                w.last_vertex  = (k == n - 1);
                send_vertex(w);
            end
            spent += n;
        end
    endtask

    // Words with random flags: missing openers, stray closers, restarts
    task automatic test_broken_sequences(input int count);
        t_in_word w;
        int       k, span;
        for (k = 0; k < count; k++) begin
            span           = random_span();
            w.vertex_x     = random_coord(span);
            w.vertex_y     = random_coord(span);
            w.query_x      = random_coord(span);
            w.query_y      = random_coord(span);
            w.first_vertex = ($urandom_range(3) == 0);
            w.last_vertex  = ($urandom_range(3) == 0);
            send_vertex(w);
        end
    endtask

    // Take result words and compare them with the oldest expectation
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
                faults++;
                $display("%0t: unexpected result word %p", $time, out_word);
            end else begin
                want = awaited_results.pop_front();
                if (want.has_segment) begin
                    results_with_segment++;
                end
                if (out_word.dist_squared !== want.dist_squared) begin
                    faults++;
                    $display("%0t: dist_squared expected %0d got %0d", $time,
                             want.dist_squared, out_word.dist_squared);
                end
                if (out_word.near_x !== want.near_x) begin
                    faults++;
                    $display("%0t: near_x expected %0d got %0d", $time,
                             want.near_x, out_word.near_x);
                end
                if (out_word.near_y !== want.near_y) begin
                    faults++;
                    $display("%0t: near_y expected %0d got %0d", $time,
                             want.near_y, out_word.near_y);
                end
                if (out_word.has_segment !== want.has_segment) begin
                    faults++;
                    $display("%0t: has_segment expected %0b got %0b", $time,
                             want.has_segment, out_word.has_segment);
                end
            end
        end
        out_stall <= rst_n && ($urandom_range(99) < stall_pct);
    end

    // Count cycles in which neither channel moves a word
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
        $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        restart_run();
        trail_x = 0;
        trail_y = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_open_without_first();
        test_lone_vertex();
        test_extremes();
        test_clamped_projection();
        test_half_rounding();
        test_tie();
        test_restart();

        // Random traffic under each idle mix
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 69; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 69; end
                default: begin send_idle_pct = 14; stall_pct = 14; end
            endcase
            test_well_formed_polylines(PHASE_VERTICES);
            test_broken_sequences(PHASE_BROKEN);
        end
        in_valid <= 1'b0;

        // Drain outstanding results, then watch for strays
        while (awaited_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d vertex words and %0d result words, %0d of them with a segment.",
                 vertices_sent, results_seen, results_with_segment);
        $display("Idle mixes: none, sender-heavy, receiver-heavy and light on both sides.");
        if (faults == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
